// ----- design/tcgw_pkg.sv -----
package tcgw_pkg;

    localparam int X_W      = 12;
    localparam int Y_W      = 12;
    localparam int MASK_W   = 8;
    localparam int COLOUR_W = 32;
    localparam int WIDTH_W  = 13;
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = 4;
    localparam int OP_W     = 2;

    localparam int CELL_ROWS  = 16;
    localparam int CELL_WIDTH = 8;

    localparam logic [Y_W-1:0]      Y_MAX        = 12'hfff;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 13'd8;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 13'd4096;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [COLOUR_W-1:0] TEXT_RESET   = 32'hffff_ffff;
    localparam logic [COLOUR_W-1:0] CLEAR_RESET  = 32'h0;
    localparam logic [MASK_W-1:0]   FULL_MASK    = 8'hff;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT  = 2'd1;
    localparam logic [OP_W-1:0] OP_BKSP = 2'd2;
    localparam logic [OP_W-1:0] OP_NL   = 2'd3;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_TEXT  = 2'd0;
    localparam logic [1:0] REG_CLEAR = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;

    typedef struct packed {
        logic put;
        logic bksp;
        logic nl;
    } t_cur_cmd;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_cell;

endpackage

// ----- design/tcgw_in_if.sv -----
interface tcgw_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcgw_pkg::OP_W-1:0]    opcode;
    logic [tcgw_pkg::CHAR_W-1:0]  char_code;
    logic [tcgw_pkg::ROW_W-1:0]   glyph_row;
    logic [tcgw_pkg::MASK_W-1:0]  font_bits;

    modport source (output valid, opcode, char_code, glyph_row, font_bits, input ready);
    modport sink   (input valid, opcode, char_code, glyph_row, font_bits, output ready);
endinterface

// ----- design/tcgw_out_if.sv -----
interface tcgw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcgw_pkg::X_W-1:0]      pixel_x;
    logic [tcgw_pkg::Y_W-1:0]      pixel_y;
    logic [tcgw_pkg::MASK_W-1:0]   pixel_mask;
    logic [tcgw_pkg::COLOUR_W-1:0] pixel_value;
    logic                          last_row;

    modport source (output valid, pixel_x, pixel_y, pixel_mask, pixel_value, last_row,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_mask, pixel_value, last_row,
                    output ready);
endinterface

// ----- design/tcgw_font_mem.sv -----
module tcgw_font_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [tcgw_pkg::MASK_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [tcgw_pkg::MASK_W-1:0] o_rd_data
);

    logic [tcgw_pkg::MASK_W-1:0] r_mem [DEPTH];
    logic [tcgw_pkg::MASK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/tcgw_cursor.sv -----
module tcgw_cursor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcgw_pkg::t_cur_cmd           i_cmd,
    input  logic [tcgw_pkg::WIDTH_W-1:0] i_width,
    output tcgw_pkg::t_cell              o_emit
);

    logic [tcgw_pkg::X_W-1:0]     r_x, n_x;
    logic [tcgw_pkg::Y_W-1:0]     r_y, n_y;
    logic [tcgw_pkg::WIDTH_W-1:0] put_nx;
    logic [tcgw_pkg::WIDTH_W:0]   put_end;
    logic [tcgw_pkg::Y_W:0]       nl_sum;
    logic [tcgw_pkg::Y_W-1:0]     nl_y;
    logic                         at_start;
    logic [tcgw_pkg::WIDTH_W-1:0] bs_base;
    logic [tcgw_pkg::WIDTH_W-1:0] bs_x;
    logic [tcgw_pkg::Y_W-1:0]     bs_y;

    always_comb begin
        put_nx  = {1'b0, r_x} + tcgw_pkg::WIDTH_W'(tcgw_pkg::CELL_WIDTH);
        put_end = {1'b0, put_nx} + (tcgw_pkg::WIDTH_W + 1)'(tcgw_pkg::CELL_WIDTH);
        nl_sum  = {1'b0, r_y} + (tcgw_pkg::Y_W + 1)'(tcgw_pkg::CELL_ROWS);
        nl_y    = nl_sum[tcgw_pkg::Y_W] ? tcgw_pkg::Y_MAX : nl_sum[tcgw_pkg::Y_W-1:0];

        // backspace at line start steps up one text line to the right edge
        at_start = r_x < tcgw_pkg::X_W'(tcgw_pkg::CELL_WIDTH);
        bs_base  = at_start ? i_width : {1'b0, r_x};
        bs_x     = bs_base - tcgw_pkg::WIDTH_W'(tcgw_pkg::CELL_WIDTH);
        if (!at_start) begin
            bs_y = r_y;
        end else if (r_y >= tcgw_pkg::Y_W'(tcgw_pkg::CELL_ROWS)) begin
            bs_y = r_y - tcgw_pkg::Y_W'(tcgw_pkg::CELL_ROWS);
        end else begin
            bs_y = '0;
        end

        n_x = r_x;
        n_y = r_y;
        if (i_cmd.put) begin
            if (put_end > {1'b0, i_width}) begin
                n_x = '0;
                n_y = nl_y;
            end else begin
                n_x = put_nx[tcgw_pkg::X_W-1:0];
            end
        end else if (i_cmd.bksp) begin
            n_x = bs_x[tcgw_pkg::X_W-1:0];
            n_y = bs_y;
        end else if (i_cmd.nl) begin
            n_x = '0;
            n_y = nl_y;
        end

        o_emit.x = i_cmd.bksp ? bs_x[tcgw_pkg::X_W-1:0] : r_x;
        o_emit.y = i_cmd.bksp ? bs_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

endmodule

// ----- design/tcgw_row_seq.sv -----
module tcgw_row_seq #(
    parameter int GLYPH_ROWS = 16,
    parameter int AW         = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_bksp,
    input  logic [AW-1:0]                 i_base,
    input  tcgw_pkg::t_cell               i_cell,
    input  logic [tcgw_pkg::COLOUR_W-1:0] i_text_colour,
    input  logic [tcgw_pkg::COLOUR_W-1:0] i_clear_colour,
    output logic                          o_busy,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [tcgw_pkg::MASK_W-1:0]   i_rd_data,
    tcgw_out_if.source                    o_out
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    localparam logic [tcgw_pkg::ROW_W-1:0] LAST_ROW = tcgw_pkg::ROW_W'(tcgw_pkg::CELL_ROWS - 1);

    t_seq_state r_state, n_state;
    logic [tcgw_pkg::ROW_W-1:0]    r_row, n_row;
    logic [AW-1:0]                 r_base, n_base;
    logic                          r_bksp;
    tcgw_pkg::t_cell               r_cell;
    logic                          r_out_vld, n_out_vld;
    logic [tcgw_pkg::X_W-1:0]      r_out_x;
    logic [tcgw_pkg::Y_W-1:0]      r_out_y;
    logic [tcgw_pkg::MASK_W-1:0]   r_out_mask;
    logic [tcgw_pkg::COLOUR_W-1:0] r_out_value;
    logic                          r_out_last;
    logic                          emit;
    logic                          row_in_glyph;
    logic [tcgw_pkg::Y_W:0]        y_sum;
    logic [tcgw_pkg::Y_W-1:0]      row_y;
    logic [tcgw_pkg::MASK_W-1:0]   row_mask;

    always_comb begin
        emit         = (r_state == S_RUN) && (!r_out_vld || o_out.ready);
        row_in_glyph = 32'(r_row) < GLYPH_ROWS;
        // row adder: y of the current row, saturated
        y_sum        = {1'b0, r_cell.y} + (tcgw_pkg::Y_W + 1)'(r_row);
        row_y        = y_sum[tcgw_pkg::Y_W] ? tcgw_pkg::Y_MAX : y_sum[tcgw_pkg::Y_W-1:0];
        if (r_bksp) begin
            row_mask = tcgw_pkg::FULL_MASK;
        end else if (row_in_glyph) begin
            row_mask = i_rd_data;
        end else begin
            row_mask = '0;
        end

        n_state   = r_state;
        n_row     = r_row;
        n_base    = r_base;
        n_out_vld = r_out_vld;
        if (o_out.valid && o_out.ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_row   = '0;
                    n_base  = i_base;
                end
            end
            S_RUN: begin
                if (emit) begin
                    n_out_vld = 1'b1;
                    n_row     = r_row + 1'b1;
                    if (r_row == LAST_ROW) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // memory is read one row ahead so its data lines up with emit
        o_rd_addr = n_base + AW'(n_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        if (i_start && r_state == S_IDLE) begin
            r_bksp <= i_bksp;
            r_cell <= i_cell;
        end
        if (emit) begin
            r_out_x     <= r_cell.x;
            r_out_y     <= row_y;
            r_out_mask  <= row_mask;
            r_out_value <= r_bksp ? i_clear_colour : i_text_colour;
            r_out_last  <= r_row == LAST_ROW;
        end
    end

    assign o_busy            = r_state != S_IDLE;
    assign o_out.valid       = r_out_vld;
    assign o_out.pixel_x     = r_out_x;
    assign o_out.pixel_y     = r_out_y;
    assign o_out.pixel_mask  = r_out_mask;
    assign o_out.pixel_value = r_out_value;
    assign o_out.last_row    = r_out_last;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("start while a cell is in progress");

    a_idle_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_row == '0)
        else $error("row counter not rewound in idle");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_row == LAST_ROW |=> r_state == S_IDLE && o_out.valid && o_out.last_row)
        else $error("last row did not end the cell");

    a_rows_descend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_row != '0 |-> row_y >= r_out_y && r_cell.x == r_out_x)
        else $error("row y or x went out of order within a cell");

endmodule

// ----- design/text_console_glyph_writer.sv -----
// Load-font-row and newline keep the input ready: the next transfer follows at once.
// Put-char and backspace: the input transfer starts the row sequencer, whose output
// register then takes one row per cycle from the font memory's single read port while
// the output does not stall, 16 rows per character, with the input not ready meanwhile.
// Synchronous active-low reset clears the cursor, sequencer and output valid and
// restores the register defaults; the font memory has no reset.
module text_console_glyph_writer #(
    parameter int GLYPH_ROWS  = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcgw_in_if.sink                      i_in,
    tcgw_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcgw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [tcgw_pkg::COLOUR_W-1:0] r_text_colour;
    logic [tcgw_pkg::COLOUR_W-1:0] r_clear_colour;
    logic [tcgw_pkg::WIDTH_W-1:0]  r_screen_width;
    logic [tcgw_pkg::WIDTH_W-1:0]  eff_width;
    logic                          cfg_wr;
    logic [1:0]                    reg_idx;

    logic                          busy;
    logic                          in_xfer;
    logic                          char_ok;
    logic                          row_ok;
    logic                          load_wr;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 base_addr;
    logic [AW-1:0]                 rd_addr;
    logic [tcgw_pkg::MASK_W-1:0]   rd_data;
    logic                          start;
    tcgw_pkg::t_cur_cmd            cur_cmd;
    tcgw_pkg::t_cell               emit_cell;

    // configuration registers
    assign reg_idx = paddr[tcgw_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_colour  <= tcgw_pkg::TEXT_RESET;
            r_clear_colour <= tcgw_pkg::CLEAR_RESET;
            r_screen_width <= tcgw_pkg::WIDTH_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                tcgw_pkg::REG_TEXT: begin
                    r_text_colour <= (pwdata == '0) ? tcgw_pkg::TEXT_RESET : pwdata;
                end
                tcgw_pkg::REG_CLEAR: begin
                    r_clear_colour <= pwdata;
                end
                tcgw_pkg::REG_WIDTH: begin
                    r_screen_width <= pwdata[tcgw_pkg::WIDTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tcgw_pkg::REG_TEXT:  prdata = r_text_colour;
            tcgw_pkg::REG_CLEAR: prdata = r_clear_colour;
            tcgw_pkg::REG_WIDTH: prdata = 32'(r_screen_width);
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        if (r_screen_width < tcgw_pkg::WIDTH_MIN) begin
            eff_width = tcgw_pkg::WIDTH_MIN;
        end else if (r_screen_width > tcgw_pkg::WIDTH_MAX) begin
            eff_width = tcgw_pkg::WIDTH_MAX;
        end else begin
            eff_width = r_screen_width;
        end
    end

    // input decode
    assign i_in.ready = !busy;
    assign in_xfer    = i_in.valid && !busy;
    assign char_ok    = 32'(i_in.char_code) < GLYPH_COUNT;
    assign row_ok     = 32'(i_in.glyph_row) < GLYPH_ROWS;
    assign base_addr  = AW'(32'(i_in.char_code) * GLYPH_ROWS);
    assign wr_addr    = base_addr + AW'(i_in.glyph_row);
    assign load_wr    = in_xfer && i_in.opcode == tcgw_pkg::OP_LOAD && char_ok && row_ok;

    always_comb begin
        cur_cmd.put  = in_xfer && i_in.opcode == tcgw_pkg::OP_PUT && char_ok;
        cur_cmd.bksp = in_xfer && i_in.opcode == tcgw_pkg::OP_BKSP;
        cur_cmd.nl   = in_xfer && i_in.opcode == tcgw_pkg::OP_NL;
        start        = cur_cmd.put || cur_cmd.bksp;
    end

    tcgw_font_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_font_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.font_bits),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tcgw_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cur_cmd),
        .i_width (eff_width),
        .o_emit  (emit_cell)
    );

    tcgw_row_seq #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .AW         (AW)
    ) u_row_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_bksp         (cur_cmd.bksp),
        .i_base         (base_addr),
        .i_cell         (emit_cell),
        .i_text_colour  (r_text_colour),
        .i_clear_colour (r_clear_colour),
        .o_busy         (busy),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_out          (o_out)
    );

endmodule
